// ===== rtl/pope_pkg.sv =====
// Package with shared constants and types for the path option payoff evaluator.
package pope_pkg;

  localparam int PRICE_W         = 32;
  localparam int PRICE_FRAC_BITS = 16;
  localparam int DISC_W          = 17;
  localparam int DISC_FRAC_BITS  = 16;
  localparam int KIND_W          = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int PROD_W          = PRICE_W + DISC_W;

  typedef logic [PRICE_W-1:0]    price_t;
  typedef logic [DISC_W-1:0]     disc_t;
  typedef logic [KIND_W-1:0]     kind_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [PROD_W-1:0]     prod_t;

  localparam cfg_idx_t CFG_STRIKE   = 3'd0;
  localparam cfg_idx_t CFG_BARRIER  = 3'd1;
  localparam cfg_idx_t CFG_DISCOUNT = 3'd2;
  localparam cfg_idx_t CFG_KIND     = 3'd3;
  localparam cfg_idx_t CFG_KNOCK_IN = 3'd4;
  localparam cfg_idx_t CFG_UP       = 3'd5;

  localparam kind_t KIND_CALL         = 3'd0;
  localparam kind_t KIND_PUT          = 3'd1;
  localparam kind_t KIND_DIGITAL_CALL = 3'd2;
  localparam kind_t KIND_DIGITAL_PUT  = 3'd3;
  localparam kind_t KIND_BARRIER_CALL = 3'd4;
  localparam kind_t KIND_BARRIER_PUT  = 3'd5;

  localparam disc_t  DISC_ONE   = disc_t'(1) << DISC_FRAC_BITS;
  localparam price_t PRICE_UNIT = price_t'(1) << PRICE_FRAC_BITS;
  localparam price_t PRICE_MAX  = '1;

endpackage

// ===== rtl/path_option_payoff_evaluator_top.sv =====
// Top level of the path option payoff evaluator: barrier tracking, payoff and discount.
//
// The block takes one path sample per cycle while in_ready is high and returns, for each
// sample marked as last, the discounted payoff together with the barrier flag at path
// end. A sample passes through three register stages: an input register, a stage that
// updates the barrier state and forms the raw payoff, and the result register that holds
// the product with the discount factor after saturation. Each stage holds its item only
// while the stage after it is full and stalled, so samples keep flowing while a result
// waits to be taken, until a second result fills the payoff stage. Configuration
// registers are written through the cfg port, which is always ready. The discount factor
// takes effect for payoffs that enter the result register afterward, the other registers
// for samples that reach the payoff stage afterward.
module path_option_payoff_evaluator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pope_pkg::price_t   in_price_sample,
  input  logic               in_first_sample,
  input  logic               in_last_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output pope_pkg::price_t   out_discounted_payoff,
  output logic               out_barrier_active,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  pope_pkg::cfg_idx_t cfg_index,
  input  pope_pkg::cfg_data_t cfg_data
);
  import pope_pkg::*;

  price_t strike_r;
  price_t barrier_r;
  disc_t  discount_r;
  kind_t  kind_r;
  logic   knock_in_r;
  logic   up_r;

  logic   s1_valid_r;
  price_t s1_price_r;
  logic   s1_first_r;
  logic   s1_last_r;

  logic   alive_r;
  logic   crossed_r;
  logic   alive_nxt;
  logic   crossed_nxt;

  logic   s2_valid_r;
  price_t s2_raw_r;
  logic   s2_alive_r;
  price_t raw_nxt;

  logic   out_valid_r;
  price_t out_payoff_r;
  logic   out_alive_r;
  price_t payoff_nxt;

  logic   out_open;
  logic   s2_ready;
  logic   s1_ready;
  logic   s1_adv;
  logic   crosses;
  logic   above;
  logic   below;
  price_t diff_up;
  price_t diff_dn;
  prod_t  prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strike_r   <= '0;
      barrier_r  <= '0;
      discount_r <= DISC_ONE;
      kind_r     <= KIND_CALL;
      knock_in_r <= 1'b0;
      up_r       <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STRIKE:   strike_r   <= cfg_data[PRICE_W-1:0];
        CFG_BARRIER:  barrier_r  <= cfg_data[PRICE_W-1:0];
        CFG_DISCOUNT: discount_r <= cfg_data[DISC_W-1:0];
        CFG_KIND:     kind_r     <= cfg_data[KIND_W-1:0];
        CFG_KNOCK_IN: knock_in_r <= cfg_data[0];
        CFG_UP:       up_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_open = !out_valid_r || out_ready;
  assign s2_ready = !s2_valid_r || out_open;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s1_adv   = s1_valid_r && s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_price_r <= in_price_sample;
      s1_first_r <= in_first_sample;
      s1_last_r  <= in_last_sample;
    end
  end

  // Put kinds use a strict barrier compare, call kinds an inclusive one.
  always_comb begin
    if (up_r) begin
      crosses = kind_r[0] ? (s1_price_r > barrier_r) : (s1_price_r >= barrier_r);
    end else begin
      crosses = kind_r[0] ? (s1_price_r < barrier_r) : (s1_price_r <= barrier_r);
    end
  end

  always_comb begin
    alive_nxt   = alive_r;
    crossed_nxt = crossed_r;
    if (s1_first_r) begin
      alive_nxt   = !knock_in_r;
      crossed_nxt = 1'b0;
    end else if (!crossed_r && crosses) begin
      alive_nxt   = !alive_r;
      crossed_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r   <= 1'b0;
      crossed_r <= 1'b0;
    end else if (s1_adv) begin
      alive_r   <= alive_nxt;
      crossed_r <= crossed_nxt;
    end
  end

  assign above   = s1_price_r > strike_r;
  assign below   = s1_price_r < strike_r;
  assign diff_up = above ? (s1_price_r - strike_r) : '0;
  assign diff_dn = below ? (strike_r - s1_price_r) : '0;

  always_comb begin
    case (kind_r)
      KIND_CALL:         raw_nxt = diff_up;
      KIND_PUT:          raw_nxt = diff_dn;
      KIND_DIGITAL_CALL: raw_nxt = above ? PRICE_UNIT : '0;
      KIND_DIGITAL_PUT:  raw_nxt = below ? PRICE_UNIT : '0;
      KIND_BARRIER_CALL: raw_nxt = alive_nxt ? diff_up : '0;
      KIND_BARRIER_PUT:  raw_nxt = alive_nxt ? diff_dn : '0;
      default:           raw_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_raw_r   <= raw_nxt;
      s2_alive_r <= alive_nxt;
    end
  end

  assign prod = prod_t'(s2_raw_r) * prod_t'(discount_r);

  // A discount factor above one can push the product past the price range.
  always_comb begin
    if (prod[PROD_W-1:DISC_FRAC_BITS + PRICE_W] != '0) begin
      payoff_nxt = PRICE_MAX;
    end else begin
      payoff_nxt = prod[DISC_FRAC_BITS +: PRICE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_open) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open) begin
      out_payoff_r <= payoff_nxt;
      out_alive_r  <= s2_alive_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_discounted_payoff = out_payoff_r;
  assign out_barrier_active    = out_alive_r;

endmodule

// ===== rtl/pope_checker.sv =====
// Port-level checker for the path option payoff evaluator and its bind statement.
module pope_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input pope_pkg::price_t    out_discounted_payoff,
  input logic                out_barrier_active,
  input logic                cfg_ready
);
  import pope_pkg::*;

  // Reset leaves no result pending.
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  // With the result side free, every stage can advance and the input is ready.
  a_in_ready_when_open: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("Input stalled while result side is free.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_discounted_payoff) && $stable(out_barrier_active)))
    else $error("Stalled result changed before transfer.");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("Configuration port not ready.");

endmodule

bind path_option_payoff_evaluator_top pope_checker u_pope_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_ready              (in_ready),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_discounted_payoff (out_discounted_payoff),
  .out_barrier_active    (out_barrier_active),
  .cfg_ready             (cfg_ready)
);

// ===== dv/tb_path_option_payoff_evaluator_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the path option payoff evaluator with directed and random paths.
module tb_path_option_payoff_evaluator_top;
  import pope_pkg::*;

  localparam int TOTAL_ITEMS    = 1150;
  localparam int MAX_GAP        = 16;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRINT_LIMIT    = 50;

  localparam cfg_idx_t CFG_SPARE_6 = 3'd6;
  localparam cfg_idx_t CFG_SPARE_7 = 3'd7;
  localparam kind_t KIND_SPARE_6   = 3'd6;
  localparam kind_t KIND_SPARE_7   = 3'd7;

  typedef struct packed {
    price_t payoff;
    logic   alive;
  } payoff_result_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  price_t    in_price_sample;
  logic      in_first_sample;
  logic      in_last_sample;
  logic      out_valid;
  logic      out_ready;
  price_t    out_discounted_payoff;
  logic      out_barrier_active;
  logic      cfg_valid;
  logic      cfg_ready;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  payoff_result_t expected_payoffs[$];

  price_t cur_strike;
  price_t cur_barrier;
  disc_t  cur_disc;
  kind_t  cur_kind;
  logic   cur_knock_in;
  logic   cur_up;
  logic   path_alive;
  logic   path_crossed;

  int mismatch_count = 0;
  int items_sent     = 0;
  int idle_cycles    = 0;
  int rx_hold        = 0;
  bit in_no_idle     = 1'b0;
  bit rx_no_idle     = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  path_option_payoff_evaluator_top u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_price_sample       (in_price_sample),
    .in_first_sample       (in_first_sample),
    .in_last_sample        (in_last_sample),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_discounted_payoff (out_discounted_payoff),
    .out_barrier_active    (out_barrier_active),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("%0t mismatch: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  function automatic price_t px(int unsigned whole);
    return price_t'(whole) << PRICE_FRAC_BITS;
  endfunction

  function automatic logic barrier_crossed(price_t s);
    if (cur_up) begin
      return cur_kind[0] ? (s > cur_barrier) : (s >= cur_barrier);
    end
    return cur_kind[0] ? (s < cur_barrier) : (s <= cur_barrier);
  endfunction

  task automatic predict_path_sample(price_t s, logic first, logic last);
    price_t above;
    price_t below;
    price_t raw;
    prod_t  scaled;
    payoff_result_t res;
    if (first) begin
      path_alive   = !cur_knock_in;
      path_crossed = 1'b0;
    end else if (!path_crossed && barrier_crossed(s)) begin
      path_alive   = !path_alive;
      path_crossed = 1'b1;
    end
    if (last) begin
      above = (s > cur_strike) ? s - cur_strike : '0;
      below = (cur_strike > s) ? cur_strike - s : '0;
      case (cur_kind)
        KIND_CALL: begin
          raw = above;
        end
        KIND_PUT: begin
          raw = below;
        end
        KIND_DIGITAL_CALL: begin
          raw = (s > cur_strike) ? PRICE_UNIT : '0;
        end
        KIND_DIGITAL_PUT: begin
          raw = (s < cur_strike) ? PRICE_UNIT : '0;
        end
        KIND_BARRIER_CALL: begin
          raw = path_alive ? above : '0;
        end
        KIND_BARRIER_PUT: begin
          raw = path_alive ? below : '0;
        end
        default: begin
          raw = '0;
        end
      endcase
      scaled = (prod_t'(raw) * prod_t'(cur_disc)) >> DISC_FRAC_BITS;
      res.payoff = (scaled > prod_t'(PRICE_MAX)) ? PRICE_MAX : scaled[PRICE_W-1:0];
      res.alive  = path_alive;
      expected_payoffs.push_back(res);
    end
  endtask

  always @(posedge clk) begin : monitor
    payoff_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_path_sample(in_price_sample, in_first_sample, in_last_sample);
      end
      if (out_valid && out_ready) begin
        if (expected_payoffs.size() == 0) begin
          report_mismatch($sformatf("unexpected result payoff=%h active=%b",
                                    out_discounted_payoff, out_barrier_active));
        end else begin
          want = expected_payoffs.pop_front();
          if (out_discounted_payoff !== want.payoff) begin
            report_mismatch($sformatf("discounted_payoff got %h want %h",
                                      out_discounted_payoff, want.payoff));
          end
          if (out_barrier_active !== want.alive) begin
            report_mismatch($sformatf("barrier_active got %b want %b",
                                      out_barrier_active, want.alive));
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin : receiver
    int hold;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        hold    = rx_hold;
        rx_hold = 0;
      end else begin
        hold = rx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid && rx_hold == 0) @(posedge clk);
    end
  end

  task automatic send_sample(price_t s, logic first, logic last);
    int gap;
    gap = in_no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_price_sample <= s;
    in_first_sample <= first;
    in_last_sample  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // The sample under transfer may still be in flight when the queue drains, so keep waiting after that.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_payoffs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_STRIKE: begin
        cur_strike = data;
      end
      CFG_BARRIER: begin
        cur_barrier = data;
      end
      CFG_DISCOUNT: begin
        cur_disc = data[DISC_W-1:0];
      end
      CFG_KIND: begin
        cur_kind = data[KIND_W-1:0];
      end
      CFG_KNOCK_IN: begin
        cur_knock_in = data[0];
      end
      CFG_UP: begin
        cur_up = data[0];
      end
      default: begin
      end
    endcase
  endtask

  function automatic cfg_data_t with_junk(cfg_data_t value, int width);
    cfg_data_t mask;
    mask = (cfg_data_t'(1) << width) - 1;
    return (cfg_data_t'($urandom) & ~mask) | (value & mask);
  endfunction

  task automatic configure(price_t strike, price_t barrier, disc_t disc, kind_t kind,
                           logic knock_in, logic up);
    settle();
    write_reg(CFG_STRIKE, strike);
    write_reg(CFG_BARRIER, barrier);
    write_reg(CFG_DISCOUNT, with_junk(cfg_data_t'(disc), DISC_W));
    write_reg(CFG_KIND, with_junk(cfg_data_t'(kind), KIND_W));
    write_reg(CFG_KNOCK_IN, with_junk(cfg_data_t'(knock_in), 1));
    write_reg(CFG_UP, with_junk(cfg_data_t'(up), 1));
    cfg_valid <= 1'b0;
  endtask

  function automatic price_t pick_price();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return PRICE_MAX;
      2, 3: return cur_barrier + price_t'($urandom_range(0, 8)) - price_t'(4);
      4, 5: return cur_strike + price_t'($urandom_range(0, 8)) - price_t'(4);
      default: return price_t'($urandom);
    endcase
  endfunction

  task automatic send_path(int len, logic mark_first, logic mark_last);
    int i;
    for (i = 0; i < len; i++) begin
      send_sample(pick_price(), mark_first && (i == 0), mark_last && (i == len - 1));
    end
  endtask

  task automatic test_reset_defaults();
    // A sample before any path start continues the state left by reset.
    send_sample('0, 1'b0, 1'b1);
    send_sample(PRICE_MAX, 1'b1, 1'b1);
  endtask

  task automatic test_payoff_kinds();
    configure(px(100), px(120), DISC_ONE, KIND_CALL, 1'b0, 1'b1);
    send_sample(px(130), 1'b1, 1'b0);
    send_sample(px(110), 1'b0, 1'b0);
    send_sample(px(120), 1'b0, 1'b1);
    send_sample(px(90), 1'b0, 1'b1);

    configure(px(100), px(120), DISC_ONE, KIND_PUT, 1'b0, 1'b1);
    send_sample(px(130), 1'b1, 1'b0);
    send_sample(px(120), 1'b0, 1'b0);
    send_sample(px(80), 1'b0, 1'b1);

    configure(px(100), px(90), DISC_ONE, KIND_DIGITAL_CALL, 1'b1, 1'b0);
    send_sample(px(100), 1'b1, 1'b0);
    send_sample(px(90), 1'b0, 1'b0);
    send_sample(px(101), 1'b0, 1'b1);
    send_sample(px(100), 1'b1, 1'b1);

    configure(px(100), px(90), DISC_ONE, KIND_DIGITAL_PUT, 1'b1, 1'b0);
    send_sample(px(99), 1'b1, 1'b1);

    configure(px(100), px(120), 17'h08000, KIND_BARRIER_CALL, 1'b0, 1'b1);
    send_sample(px(110), 1'b1, 1'b0);
    send_sample(px(119), 1'b0, 1'b1);
    send_sample(px(110), 1'b1, 1'b0);
    send_sample(px(121), 1'b0, 1'b1);

    configure(px(100), px(90), disc_t'('1), KIND_BARRIER_PUT, 1'b1, 1'b0);
    send_sample(px(100), 1'b1, 1'b0);
    send_sample(px(90), 1'b0, 1'b0);
    send_sample(px(89), 1'b0, 1'b1);

    configure('0, px(10), disc_t'('1), KIND_CALL, 1'b0, 1'b1);
    send_sample(PRICE_MAX, 1'b1, 1'b1);

    configure(px(1), px(3), DISC_ONE, KIND_SPARE_6, 1'b0, 1'b1);
    send_sample(px(5), 1'b1, 1'b0);
    send_sample(px(3), 1'b0, 1'b1);

    configure(px(1), px(3), DISC_ONE, KIND_SPARE_7, 1'b1, 1'b0);
    send_sample(px(2), 1'b1, 1'b1);
  endtask

  task automatic test_spare_registers();
    configure(px(50), px(60), DISC_ONE, KIND_BARRIER_CALL, 1'b0, 1'b1);
    write_reg(CFG_SPARE_6, cfg_data_t'($urandom));
    write_reg(CFG_SPARE_7, cfg_data_t'($urandom));
    cfg_valid <= 1'b0;
    send_sample(px(70), 1'b1, 1'b1);
    send_sample(px(10), 1'b1, 1'b0);
    send_sample(px(59), 1'b0, 1'b1);
  endtask

  task automatic test_output_backpressure();
    int i;
    configure(px(10), px(20), DISC_ONE, KIND_BARRIER_CALL, 1'b0, 1'b1);
    in_no_idle = 1'b1;
    rx_hold    = LONG_HOLD;
    for (i = 0; i < 40; i++) begin
      send_sample(pick_price(), (i % 3) == 0, 1'b1);
    end
    in_no_idle = 1'b0;
    settle();
  endtask

  task automatic test_random_paths();
    int     phase_end;
    price_t strike;
    price_t barrier;
    disc_t  disc;
    kind_t  kind;
    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 7))
        0: strike = '0;
        1: strike = PRICE_MAX;
        default: strike = price_t'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0: barrier = '0;
        1: barrier = PRICE_MAX;
        2, 3: barrier = strike + price_t'($urandom_range(0, 64)) - price_t'(32);
        default: barrier = price_t'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0: disc = '0;
        1: disc = DISC_ONE;
        2: disc = disc_t'('1);
        3: disc = disc_t'($urandom_range(DISC_ONE, 2 ** DISC_W - 1));
        default: disc = disc_t'($urandom_range(0, DISC_ONE));
      endcase
      kind = ($urandom_range(0, 15) < 2) ? kind_t'($urandom_range(6, 7))
                                         : kind_t'($urandom_range(0, 5));
      configure(strike, barrier, disc, kind, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      in_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = ($urandom_range(0, 3) == 0);
      phase_end  = items_sent + $urandom_range(30, 90);
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0: send_sample(pick_price(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          1: send_path($urandom_range(1, 12), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
          default: send_path($urandom_range(1, 12), 1'b1, 1'b1);
        endcase
      end
    end
    in_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_price_sample = '0;
    in_first_sample = 1'b0;
    in_last_sample  = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    cur_strike      = '0;
    cur_barrier     = '0;
    cur_disc        = DISC_ONE;
    cur_kind        = KIND_CALL;
    cur_knock_in    = 1'b0;
    cur_up          = 1'b1;
    path_alive      = 1'b0;
    path_crossed    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_payoff_kinds();
    test_spare_registers();
    test_output_backpressure();
    test_random_paths();
    settle();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
